[hw/rtl/i2cms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // bus command codes
  typedef enum logic [2:0] {
    REQ_START     = 3'd0,
    REQ_STOP      = 3'd1,
    REQ_WRITE     = 3'd2,
    REQ_READ      = 3'd3,
    REQ_SEND_ACK  = 3'd4,
    REQ_SEND_NAK  = 3'd5,
    REQ_CHECK_ACK = 3'd6
  } req_t;

  // what one bus phase changes
  typedef enum logic [1:0] {
    ACT_SCL = 2'd0,
    ACT_SDA = 2'd1,
    ACT_REL = 2'd2
  } act_kind_t;

  typedef struct packed {
    act_kind_t kind;
    logic      lvl;
    logic      fin;
  } act_t;

  localparam int unsigned PHASE_W = 5;   // longest run is 25 phases
  localparam int unsigned WRITE_LAST = 24;
  localparam int unsigned READ_LAST = 18;
  localparam int unsigned CHECK_ACK_LAST = 4;
  localparam int unsigned CHECK_STOP_BASE = 5;

endpackage

[hw/rtl/i2c_master_bit_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// Turns one I2C bus command into its run of bus phases (SCL, SDA, SDA enable).
// The first phase of a command is registered in the result register after its item is taken.
// One phase per cycle while the result register is not stalled; a command has 4 to 25 phases,
// counted by the phase counter; the next item is taken in the cycle of the last phase.
// An unknown command emits no phase.
// Reset (rst_n low, synchronous): sequencer idle, no result pending,
// bus state SCL low, SDA high, SDA driven.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_tx_byte,
  input  logic [7:0] in_partner_bits,
  input  logic       in_partner_ack_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_sda_drive_enable,
  output logic [7:0] out_rx_byte,
  output logic       out_nak_seen,
  output logic       out_last_phase
);
  import i2cms_pkg::*;

  // command register
  logic               busy_r;
  req_t               cmd_r;
  logic [7:0]         tx_sh_r;
  logic [7:0]         rx_r;
  logic               ack_r;
  logic [PHASE_W-1:0] idx_r;
  logic [1:0]         sub_r;

  // bus state
  logic scl_r, sda_r, drv_r;
  logic scl_nxt, sda_nxt, drv_nxt;

  // result register
  logic       out_valid_r;
  logic       out_scl_r, out_sda_r, out_drv_r, out_nak_r, out_last_r;
  logic [7:0] out_rx_r;

  logic       advance;
  logic       accept;
  act_t       act;
  logic [2:0] stop_idx;

  // stop sequence: sda0, scl0, scl1, sda1, scl0
  function automatic act_t stop_action(input logic [2:0] k);
    act_t a;
    a = '{kind: ACT_SCL, lvl: 1'b0, fin: 1'b0};
    case (k)
      3'd0: a = '{kind: ACT_SDA, lvl: 1'b0, fin: 1'b0};
      3'd1: a = '{kind: ACT_SCL, lvl: 1'b0, fin: 1'b0};
      3'd2: a = '{kind: ACT_SCL, lvl: 1'b1, fin: 1'b0};
      3'd3: a = '{kind: ACT_SDA, lvl: 1'b1, fin: 1'b0};
      default: a = '{kind: ACT_SCL, lvl: 1'b0, fin: 1'b1};
    endcase
    return a;
  endfunction

  assign stop_idx = 3'(idx_r - PHASE_W'(CHECK_STOP_BASE));

  // phase decode for the current command
  always_comb begin
    act = '{kind: ACT_SCL, lvl: 1'b0, fin: 1'b0};
    case (cmd_r)
      REQ_START: begin
        case (idx_r)
          5'd0: act = '{kind: ACT_SDA, lvl: 1'b1, fin: 1'b0};
          5'd1: act = '{kind: ACT_SCL, lvl: 1'b1, fin: 1'b0};
          5'd2: act = '{kind: ACT_SDA, lvl: 1'b0, fin: 1'b0};
          default: act = '{kind: ACT_SCL, lvl: 1'b0, fin: 1'b1};
        endcase
      end
      REQ_STOP: act = stop_action(idx_r[2:0]);
      REQ_WRITE: begin
        if (idx_r == PHASE_W'(WRITE_LAST)) begin
          act = '{kind: ACT_SCL, lvl: 1'b0, fin: 1'b1};
        end else begin
          case (sub_r)
            2'd0: act = '{kind: ACT_SCL, lvl: 1'b0, fin: 1'b0};
            2'd1: act = '{kind: ACT_SDA, lvl: tx_sh_r[7], fin: 1'b0};
            default: act = '{kind: ACT_SCL, lvl: 1'b1, fin: 1'b0};
          endcase
        end
      end
      REQ_READ: begin
        if (idx_r == 5'd0) begin
          act = '{kind: ACT_SDA, lvl: 1'b1, fin: 1'b0};
        end else if (idx_r == 5'd1) begin
          act = '{kind: ACT_REL, lvl: 1'b0, fin: 1'b0};
        end else if (idx_r == PHASE_W'(READ_LAST)) begin
          act = '{kind: ACT_SCL, lvl: 1'b0, fin: 1'b1};
        end else begin
          // even phases drop scl, odd phases raise it
          act = '{kind: ACT_SCL, lvl: idx_r[0], fin: 1'b0};
        end
      end
      REQ_SEND_ACK, REQ_SEND_NAK: begin
        case (idx_r)
          5'd0: act = '{kind: ACT_SCL, lvl: 1'b0, fin: 1'b0};
          5'd1: act = '{kind: ACT_SDA, lvl: (cmd_r == REQ_SEND_NAK), fin: 1'b0};
          5'd2: act = '{kind: ACT_SCL, lvl: 1'b1, fin: 1'b0};
          default: act = '{kind: ACT_SCL, lvl: 1'b0, fin: 1'b1};
        endcase
      end
      REQ_CHECK_ACK: begin
        case (idx_r)
          5'd0: act = '{kind: ACT_SDA, lvl: 1'b1, fin: 1'b0};
          5'd1: act = '{kind: ACT_SCL, lvl: 1'b0, fin: 1'b0};
          5'd2: act = '{kind: ACT_REL, lvl: 1'b0, fin: 1'b0};
          5'd3: act = '{kind: ACT_SCL, lvl: 1'b1, fin: 1'b0};
          PHASE_W'(CHECK_ACK_LAST): act = '{kind: ACT_SCL, lvl: 1'b0, fin: !ack_r};
          // nak repair: full stop after the ack slot
          default: act = stop_action(stop_idx);
        endcase
      end
      default: act = '{kind: ACT_SCL, lvl: 1'b0, fin: 1'b1};
    endcase
  end

  // bus state update for this phase
  always_comb begin
    scl_nxt = scl_r;
    sda_nxt = sda_r;
    drv_nxt = drv_r;
    case (act.kind)
      ACT_SCL: scl_nxt = act.lvl;
      ACT_SDA: begin
        sda_nxt = act.lvl;
        drv_nxt = 1'b1;
      end
      ACT_REL: drv_nxt = 1'b0;
      default: drv_nxt = drv_r;
    endcase
  end

  // handshake
  assign advance  = busy_r && (!out_valid_r || out_ready);
  assign in_ready = !busy_r || (advance && act.fin);
  assign accept   = in_valid && in_ready;

  // sequencer and bus state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      scl_r  <= 1'b0;
      sda_r  <= 1'b1;
      drv_r  <= 1'b1;
    end else begin
      if (advance) begin
        scl_r <= scl_nxt;
        sda_r <= sda_nxt;
        drv_r <= drv_nxt;
        idx_r <= idx_r + PHASE_W'(1);
        sub_r <= (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;
        if (act.kind == ACT_SDA) begin
          tx_sh_r <= {tx_sh_r[6:0], 1'b0};
        end
        if (act.fin) begin
          busy_r <= 1'b0;
        end
      end
      // a new item overrides the finishing one
      if (accept) begin
        busy_r  <= (in_req_type <= REQ_CHECK_ACK);
        cmd_r   <= req_t'(in_req_type);
        tx_sh_r <= in_tx_byte;
        rx_r    <= in_partner_bits;
        ack_r   <= in_partner_ack_level;
        idx_r   <= '0;
        sub_r   <= 2'd0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        out_scl_r   <= scl_nxt;
        out_sda_r   <= drv_nxt & sda_nxt;
        out_drv_r   <= drv_nxt;
        out_rx_r    <= (cmd_r == REQ_READ && act.fin) ? rx_r : 8'd0;
        out_nak_r   <= (cmd_r == REQ_CHECK_ACK && act.fin) ? ack_r : 1'b0;
        out_last_r  <= act.fin;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_scl_level        = out_scl_r;
  assign out_sda_level        = out_sda_r;
  assign out_sda_drive_enable = out_drv_r;
  assign out_rx_byte          = out_rx_r;
  assign out_nak_seen         = out_nak_r;
  assign out_last_phase       = out_last_r;

endmodule

[hw/rtl/i2cms_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cms_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_scl_level,
  input logic       out_sda_level,
  input logic       out_sda_drive_enable,
  input logic [7:0] out_rx_byte,
  input logic       out_nak_seen,
  input logic       out_last_phase
);

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scl_level)
      && $stable(out_sda_level) && $stable(out_sda_drive_enable)
      && $stable(out_last_phase))
    else $error("stalled result item changed");

  // received byte and nak flag only on the last phase of a run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_phase |-> out_rx_byte == 8'd0 && !out_nak_seen)
    else $error("rx byte or nak flag outside the last phase");

  // released sda reads low
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sda_drive_enable |-> !out_sda_level)
    else $error("sda level set while released");

  // reset leaves the sequencer idle and ready
  assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("sequencer not idle after reset");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_scl_level        (out_scl_level),
  .out_sda_level        (out_sda_level),
  .out_sda_drive_enable (out_sda_drive_enable),
  .out_rx_byte          (out_rx_byte),
  .out_nak_seen         (out_nak_seen),
  .out_last_phase       (out_last_phase)
);

[verif/i2c_master_bit_sequencer_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core_test
// Drives bus commands into the sequencer and checks each bus phase against a
// built-in model of the SCL/SDA sequences. Directed corner commands come
// first, then random I2C transactions mixed with broken sequences and noise,
// under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core_test;
  import i2cms_pkg::*;

  localparam logic [2:0] REQ_UNKNOWN = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 214;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;
  localparam longint unsigned TIMEOUT_NS = 2_000_000;

  // one command item as queued for the driver
  typedef struct packed {
    logic [2:0] req;
    logic [7:0] tx;
    logic [7:0] pbits;
    logic       ack;
    logic       hold;
  } bus_cmd_t;

  // one bus phase as seen on the result channel
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       sda_en;
    logic [7:0] rx;
    logic       nak;
    logic       last;
  } bus_phase_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_req_type = REQ_START;
  logic [7:0] in_tx_byte = 8'h00;
  logic [7:0] in_partner_bits = 8'h00;
  logic       in_partner_ack_level = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_scl_level;
  logic       out_sda_level;
  logic       out_sda_drive_enable;
  logic [7:0] out_rx_byte;
  logic       out_nak_seen;
  logic       out_last_phase;

  i2c_master_bit_sequencer_core uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_tx_byte           (in_tx_byte),
    .in_partner_bits      (in_partner_bits),
    .in_partner_ack_level (in_partner_ack_level),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_scl_level        (out_scl_level),
    .out_sda_level        (out_sda_level),
    .out_sda_drive_enable (out_sda_drive_enable),
    .out_rx_byte          (out_rx_byte),
    .out_nak_seen         (out_nak_seen),
    .out_last_phase       (out_last_phase)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bus_cmd_t   pending_cmds[$];
  bus_phase_t expected_phases[$];
  bus_phase_t cmd_phases[$];

  // modeled bus state
  logic bus_scl = 1'b0;
  logic bus_sda = 1'b1;
  logic bus_drv = 1'b1;

  int unsigned errors = 0;
  int unsigned stim_items = 0;
  int unsigned phases_checked = 0;
  int unsigned naks_checked = 0;
  int unsigned cmds_taken[8];
  logic        in_taken = 1'b0;
  int          gap_left = 0;
  int          burst_left = 4;
  int unsigned stall_tick = 0;

  // phase recording for the model
  function automatic void log_phase();
    bus_phase_t p;
    p.scl = bus_scl;
    p.sda = bus_drv ? bus_sda : 1'b0;
    p.sda_en = bus_drv;
    p.rx = 8'h00;
    p.nak = 1'b0;
    p.last = 1'b0;
    cmd_phases.push_back(p);
  endfunction

  function automatic void drive_sda(input logic lvl);
    bus_drv = 1'b1;
    bus_sda = lvl;
    log_phase();
  endfunction

  function automatic void drive_scl(input logic lvl);
    bus_scl = lvl;
    log_phase();
  endfunction

  function automatic void free_sda();
    bus_drv = 1'b0;
    log_phase();
  endfunction

  function automatic void seq_stop();
    drive_sda(1'b0);
    drive_scl(1'b0);
    drive_scl(1'b1);
    drive_sda(1'b1);
    drive_scl(1'b0);
  endfunction

  function automatic void seq_answer(input logic lvl);
    drive_scl(1'b0);
    drive_sda(lvl);
    drive_scl(1'b1);
    drive_scl(1'b0);
  endfunction

  // expected bus phases of one accepted command
  function automatic void predict_bus_phases(input bus_cmd_t cmd);
    bus_phase_t p;
    cmd_phases.delete();
    case (cmd.req)
      REQ_START: begin
        drive_sda(1'b1);
        drive_scl(1'b1);
        drive_sda(1'b0);
        drive_scl(1'b0);
      end
      REQ_STOP: seq_stop();
      REQ_WRITE: begin
        for (int i = 7; i >= 0; i--) begin
          drive_scl(1'b0);
          drive_sda(cmd.tx[i]);
          drive_scl(1'b1);
        end
        drive_scl(1'b0);
      end
      REQ_READ: begin
        drive_sda(1'b1);
        free_sda();
        for (int i = 0; i < 8; i++) begin
          drive_scl(1'b0);
          drive_scl(1'b1);
        end
        drive_scl(1'b0);
      end
      REQ_SEND_ACK: seq_answer(1'b0);
      REQ_SEND_NAK: seq_answer(1'b1);
      REQ_CHECK_ACK: begin
        drive_sda(1'b1);
        drive_scl(1'b0);
        free_sda();
        drive_scl(1'b1);
        drive_scl(1'b0);
        // nak repair: drop out with a full stop
        if (cmd.ack) seq_stop();
      end
      default: ;
    endcase
    if (cmd_phases.size() != 0) begin
      p = cmd_phases.pop_back();
      p.last = 1'b1;
      if (cmd.req == REQ_READ) p.rx = cmd.pbits;
      if (cmd.req == REQ_CHECK_ACK) p.nak = cmd.ack;
      cmd_phases.push_back(p);
    end
    foreach (cmd_phases[i]) expected_phases.push_back(cmd_phases[i]);
  endfunction

  function automatic void note_failure(input string what, input bus_phase_t want,
                                       input bus_phase_t got);
    string want_s;
    string got_s;
    errors++;
    if (errors <= MAX_REPORTS) begin
      want_s = $sformatf("scl=%0b sda=%0b en=%0b rx=%02h nak=%0b last=%0b",
                         want.scl, want.sda, want.sda_en, want.rx, want.nak, want.last);
      got_s = $sformatf("scl=%0b sda=%0b en=%0b rx=%02h nak=%0b last=%0b",
                        got.scl, got.sda, got.sda_en, got.rx, got.nak, got.last);
      $display("%t %s: expected %s, got %s", $realtime, what, want_s, got_s);
    end
  endfunction

  // stimulus queue helpers
  function automatic void queue_cmd(input logic [2:0] req, input logic [7:0] tx,
                                    input logic [7:0] pbits, input logic ack,
                                    input logic hold);
    bus_cmd_t c;
    c.req = req;
    c.tx = tx;
    c.pbits = pbits;
    c.ack = ack;
    c.hold = hold;
    pending_cmds.push_back(c);
    if (req != REQ_UNKNOWN) stim_items++;
  endfunction

  function automatic void queue_rand(input logic [2:0] req, input logic ack,
                                     input logic hold);
    queue_cmd(req, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), ack, hold);
  endfunction

  function automatic logic rand_nak(input int unsigned odds);
    return ($urandom_range(1, odds) == 1);
  endfunction

  // one well-formed transaction with random content, sometimes cut short
  function automatic void queue_transaction(input logic hold);
    logic nak;
    logic rd;
    int unsigned n;
    queue_rand(REQ_START, rand_nak(2), hold);
    nak = rand_nak(8);
    queue_rand(REQ_WRITE, rand_nak(2), 1'b0);
    queue_rand(REQ_CHECK_ACK, nak, 1'b0);
    if (nak) return;
    n = $urandom_range(1, 4);
    rd = 1'($urandom_range(0, 1));
    for (int unsigned i = 0; i < n; i++) begin
      if (rd) begin
        queue_rand(REQ_READ, rand_nak(2), 1'b0);
        queue_rand((i == n - 1) ? REQ_SEND_NAK : REQ_SEND_ACK, rand_nak(2), 1'b0);
      end else begin
        nak = rand_nak(10);
        queue_rand(REQ_WRITE, rand_nak(2), 1'b0);
        queue_rand(REQ_CHECK_ACK, nak, 1'b0);
        if (nak) return;
      end
    end
    queue_rand(REQ_STOP, rand_nak(2), 1'b0);
  endfunction

  // driver and receiver stall pattern
  always @(negedge clk) begin
    bus_cmd_t nxt;
    rx_mode_t mode;
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() == 0 ||
                   (pending_cmds[0].hold && expected_phases.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        nxt = pending_cmds.pop_front();
        in_valid <= 1'b1;
        in_req_type <= nxt.req;
        in_tx_byte <= nxt.tx;
        in_partner_bits <= nxt.pbits;
        in_partner_ack_level <= nxt.ack;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
    // receiver: free-running, random and periodic stretches
    stall_tick <= stall_tick + 1;
    mode = rx_mode_t'((stall_tick / 300) % 3);
    case (mode)
      RX_FREE:    out_ready <= 1'b1;
      RX_RANDOM:  out_ready <= ($urandom_range(0, 9) > 2);
      RX_PATTERN: out_ready <= ((stall_tick % 7) < 4);
      default:    out_ready <= 1'b1;
    endcase
  end

  // monitor: predict on accepted items, check accepted phases
  always @(posedge clk) begin
    bus_cmd_t   cmd;
    bus_phase_t got;
    bus_phase_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        cmd = {in_req_type, in_tx_byte, in_partner_bits, in_partner_ack_level, 1'b0};
        predict_bus_phases(cmd);
        cmds_taken[in_req_type]++;
      end
      if (out_valid && out_ready) begin
        got = {out_scl_level, out_sda_level, out_sda_drive_enable, out_rx_byte,
               out_nak_seen, out_last_phase};
        if (expected_phases.size() == 0) begin
          note_failure("phase with nothing expected", got, got);
        end else begin
          want = expected_phases.pop_front();
          if (got !== want) note_failure("phase mismatch", want, got);
          phases_checked++;
          if (want.nak) naks_checked++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    // directed corners
    queue_cmd(REQ_START, 8'h00, 8'h00, 1'b0, 1'b0);
    queue_cmd(REQ_WRITE, 8'h00, 8'hff, 1'b1, 1'b0);
    queue_cmd(REQ_CHECK_ACK, 8'hff, 8'hff, 1'b0, 1'b0);
    queue_cmd(REQ_WRITE, 8'hff, 8'h00, 1'b0, 1'b0);
    queue_cmd(REQ_CHECK_ACK, 8'h00, 8'h00, 1'b1, 1'b0);
    queue_cmd(REQ_START, 8'hff, 8'hff, 1'b1, 1'b1);
    queue_cmd(REQ_WRITE, 8'h80, 8'h01, 1'b0, 1'b0);
    queue_cmd(REQ_CHECK_ACK, 8'h5a, 8'ha5, 1'b0, 1'b0);
    queue_cmd(REQ_READ, 8'hff, 8'h00, 1'b1, 1'b0);
    queue_cmd(REQ_SEND_ACK, 8'hff, 8'hff, 1'b1, 1'b0);
    queue_cmd(REQ_READ, 8'h00, 8'hff, 1'b0, 1'b0);
    queue_cmd(REQ_SEND_ACK, 8'h00, 8'h00, 1'b0, 1'b0);
    queue_cmd(REQ_READ, 8'h3c, 8'ha5, 1'b1, 1'b0);
    queue_cmd(REQ_SEND_NAK, 8'hc3, 8'h5a, 1'b0, 1'b0);
    queue_cmd(REQ_STOP, 8'hff, 8'hff, 1'b1, 1'b0);
    queue_cmd(REQ_UNKNOWN, 8'hff, 8'hff, 1'b1, 1'b0);
    queue_cmd(REQ_STOP, 8'h00, 8'h00, 1'b0, 1'b1);
    queue_cmd(REQ_WRITE, 8'h01, 8'h80, 1'b1, 1'b0);
    queue_cmd(REQ_SEND_NAK, 8'h00, 8'h00, 1'b0, 1'b0);
    queue_cmd(REQ_CHECK_ACK, 8'h00, 8'h00, 1'b1, 1'b0);
    // random transactions, with noise and broken sequences mixed in
    for (int unsigned t = 0; stim_items < RANDOM_ITEMS + 20; t++) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3))
          queue_rand(3'($urandom_range(0, 7)), rand_nak(2), 1'b0);
      end else begin
        queue_transaction(t % 6 == 5);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (expected_phases.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d commands: start %0d, stop %0d, write %0d, read %0d, ack %0d, nak %0d",
             stim_items, cmds_taken[REQ_START], cmds_taken[REQ_STOP], cmds_taken[REQ_WRITE],
             cmds_taken[REQ_READ], cmds_taken[REQ_SEND_ACK], cmds_taken[REQ_SEND_NAK]);
    $display("check ack %0d (%0d nak repairs), unknown %0d, %0d bus phases checked, %0d errors",
             cmds_taken[REQ_CHECK_ACK], naks_checked, cmds_taken[REQ_UNKNOWN],
             phases_checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d items queued and %0d phases outstanding",
             pending_cmds.size(), expected_phases.size());
    $display("FAIL");
    $finish;
  end

endmodule
